/* src/rme_pkg.sv */
package rme_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ANG_TABLE_LEN = 24;
  localparam int CORDIC_N = (CORDIC_STAGES < ANG_TABLE_LEN) ? CORDIC_STAGES : ANG_TABLE_LEN;
  localparam int SQRT_STAGES = 30;
  localparam int STAGE_W = 5;
  localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
  localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } side_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [29:0] root;
    logic [31:0] sq;
    side_t       side;
  } sqrt_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               zero;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } cordic_t;

  function automatic logic signed [32:0] atan_q28(input logic [STAGE_W-1:0] i);
    logic signed [32:0] t;
    case (i)
      5'd0:  t = 33'sd210828714;
      5'd1:  t = 33'sd124459457;
      5'd2:  t = 33'sd65760959;
      5'd3:  t = 33'sd33381290;
      5'd4:  t = 33'sd16755422;
      5'd5:  t = 33'sd8385879;
      5'd6:  t = 33'sd4193963;
      5'd7:  t = 33'sd2097109;
      5'd8:  t = 33'sd1048571;
      5'd9:  t = 33'sd524287;
      5'd10: t = 33'sd262144;
      5'd11: t = 33'sd131072;
      5'd12: t = 33'sd65536;
      5'd13: t = 33'sd32768;
      5'd14: t = 33'sd16384;
      5'd15: t = 33'sd8192;
      5'd16: t = 33'sd4096;
      5'd17: t = 33'sd2048;
      5'd18: t = 33'sd1024;
      5'd19: t = 33'sd512;
      5'd20: t = 33'sd256;
      5'd21: t = 33'sd128;
      5'd22: t = 33'sd64;
      5'd23: t = 33'sd32;
      default: t = '0;
    endcase
    return t;
  endfunction

  // quadrant fold so the vectoring loop starts with x >= 0
  function automatic lane_t prerot(input logic signed [33:0] y, input logic signed [33:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.z = HALF_PI_Q28;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -HALF_PI_Q28;
      end
    end
    return l;
  endfunction

  function automatic logic signed [15:0] finish(input lane_t l);
    logic signed [32:0] r;
    logic signed [15:0] a;
    r = (l.z + 33'sd16384) >>> 15;
    if (r > 33'(ANGLE_LIMIT)) a = ANGLE_LIMIT;
    else if (r < -33'(ANGLE_LIMIT)) a = -ANGLE_LIMIT;
    else a = r[15:0];
    if (l.zero) a = '0;
    return a;
  endfunction

endpackage

/* src/rme_sqrt_cell.sv */
module rme_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  rme_pkg::sqrt_t in_data,
  output logic           out_valid,
  output rme_pkg::sqrt_t out_data
);
  import rme_pkg::*;

  logic [31:0] rem_w;
  logic [31:0] trial;
  sqrt_t       nxt;

  always_comb begin
    rem_w = {in_data.rem[29:0], in_data.sq[31:30]};
    trial = {in_data.root, 2'b01};
    nxt = in_data;
    nxt.sq = {in_data.sq[29:0], 2'b00};
    if (rem_w >= trial) begin
      nxt.rem = rem_w - trial;
      nxt.root = {in_data.root[28:0], 1'b1};
    end else begin
      nxt.rem = rem_w;
      nxt.root = {in_data.root[28:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= nxt;
    end
  end
endmodule

/* src/rme_cordic_cell.sv */
module rme_cordic_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [rme_pkg::STAGE_W-1:0]  stage,
  input  logic                         in_valid,
  input  rme_pkg::cordic_t             in_data,
  output logic                         out_valid,
  output rme_pkg::cordic_t             out_data
);
  import rme_pkg::*;

  logic signed [32:0] t;
  cordic_t            nxt;

  function automatic lane_t rot(input lane_t l, input logic [STAGE_W-1:0] s,
                                input logic signed [32:0] ang);
    lane_t o;
    logic signed [33:0] a;
    logic signed [33:0] b;
    a = l.x >>> s;
    b = l.y >>> s;
    o = l;
    if (!l.y[33]) begin
      o.x = l.x + b;
      o.y = l.y - a;
      o.z = l.z + ang;
    end else begin
      o.x = l.x - b;
      o.y = l.y + a;
      o.z = l.z - ang;
    end
    return o;
  endfunction

  always_comb begin
    t = atan_q28(stage);
    nxt = in_data;
    nxt.roll = rot(in_data.roll, stage, t);
    nxt.pitch = rot(in_data.pitch, stage, t);
    nxt.yaw = rot(in_data.yaw, stage, t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= nxt;
    end
  end
endmodule

/* src/rotation_matrix_to_euler_angles_top.sv */
// Pose transform to translation plus roll, pitch and yaw.
// Input channel: in_valid / in_stall with rotation entries rot_* (Q2.14) and
// translation pos_*. Output channel: out_valid / out_stall with out_x..z
// (translation unchanged) and roll/pitch/yaw angles in Q3.13 radians.
// A word is taken on every edge where valid is high and stall is low.
// Throughput: one word per cycle unless out_stall holds the output word.
// The word passes two input registers, the 30-cell square-root chain that
// feeds the pitch CORDIC, a pre-rotation register, the CORDIC row, the output.
// The pipeline moves as one: while the output word is held by out_stall,
// every stage holds and in_stall is raised; bubbles never stall.
// Synchronous reset clears all valid bits; payload registers keep no reset.
module rotation_matrix_to_euler_angles_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] rot_00,
  input  logic signed [15:0] rot_10,
  input  logic signed [15:0] rot_20,
  input  logic signed [15:0] rot_21,
  input  logic signed [15:0] rot_22,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic signed [23:0] out_z,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] yaw_angle
);
  import rme_pkg::*;

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic               v0;
  logic               v1;
  side_t              side0;
  logic signed [31:0] sq21;
  logic signed [31:0] sq22;
  sqrt_t              s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
    end
    if (en) begin
      side0 <= '{pos_x, pos_y, pos_z, rot_00, rot_10, rot_20, rot_21, rot_22};
      sq21 <= 32'(rot_21) * 32'(rot_21);
      sq22 <= 32'(rot_22) * 32'(rot_22);
      s1.rem <= '0;
      s1.root <= '0;
      s1.sq <= 32'(sq21) + 32'(sq22);
      s1.side <= side0;
    end
  end

  logic  sv [SQRT_STAGES+1];
  sqrt_t sd [SQRT_STAGES+1];
  assign sv[0] = v1;
  assign sd[0] = s1;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    rme_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sv[g]), .in_data(sd[g]),
      .out_valid(sv[g+1]), .out_data(sd[g+1])
    );
  end

  side_t   sl;
  logic    pv;
  cordic_t pd;
  assign sl = sd[SQRT_STAGES].side;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= sv[SQRT_STAGES];
    end
    if (en) begin
      pd.roll <= prerot(34'(sl.r21) <<< 14, 34'(sl.r22) <<< 14);
      pd.pitch <= prerot(-(34'(sl.r20) <<< 14), {4'b0, sd[SQRT_STAGES].root});
      pd.yaw <= prerot(34'(sl.r10) <<< 14, 34'(sl.r00) <<< 14);
      pd.pos_x <= sl.pos_x;
      pd.pos_y <= sl.pos_y;
      pd.pos_z <= sl.pos_z;
    end
  end

  logic    cv [CORDIC_N+1];
  cordic_t cd [CORDIC_N+1];
  assign cv[0] = pv;
  assign cd[0] = pd;

  for (genvar g = 0; g < CORDIC_N; g++) begin : g_cordic
    rme_cordic_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .stage(STAGE_W'(g)),
      .in_valid(cv[g]), .in_data(cd[g]),
      .out_valid(cv[g+1]), .out_data(cd[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[CORDIC_N];
    end
    if (en) begin
      out_x <= cd[CORDIC_N].pos_x;
      out_y <= cd[CORDIC_N].pos_y;
      out_z <= cd[CORDIC_N].pos_z;
      roll_angle <= finish(cd[CORDIC_N].roll);
      pitch_angle <= finish(cd[CORDIC_N].pitch);
      yaw_angle <= finish(cd[CORDIC_N].yaw);
    end
  end

`ifndef SYNTH
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(roll_angle) && $stable(out_x))
    else $error("held word lost");
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> roll_angle <= ANGLE_LIMIT && roll_angle >= -ANGLE_LIMIT
      && pitch_angle <= ANGLE_LIMIT && pitch_angle >= -ANGLE_LIMIT
      && yaw_angle <= ANGLE_LIMIT && yaw_angle >= -ANGLE_LIMIT)
    else $error("angle out of range");
`endif
endmodule
